// ===== rtl/core/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the strict-priority message queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int unsigned HANDLE_W      = 32;
    localparam int unsigned SIZE_W        = 32;
    localparam int unsigned BYTES_W       = 32;
    localparam int unsigned PRIO_W        = 2;
    localparam int unsigned LEVEL_COUNT_W = 5;
    localparam int unsigned SLOT_W        = HANDLE_W + SIZE_W;

    // capacity registers, one per priority, index = priority
    localparam int unsigned NUM_CAP_REGS  = 4;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = BYTES_W;
    localparam logic [BYTES_W-1:0] CAP_RESET = BYTES_W'(65536);

    localparam int unsigned DEF_PRIORITY_LEVELS = 4;
    localparam int unsigned DEF_FIFO_DEPTH      = 16;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // what the first stage decided for an item
    typedef enum logic [2:0] {
        KIND_ENQ,       // appended to its FIFO
        KIND_DEQ,       // head taken from the most urgent FIFO
        KIND_OVERFLOW,  // enqueue to a full FIFO
        KIND_IGNORE,    // enqueue at a priority that does not exist
        KIND_EMPTY      // dequeue with every FIFO empty
    } t_kind;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [PRIO_W-1:0]  prio;
    } t_s1_ctl;

endpackage

// ===== rtl/core/smpq_ram.sv =====
// ----------------------------------------------------------------------------
// smpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smpq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/smpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpq_ctrl
// Input stage: FIFO pointers and counts, priority select, slot store access.
// ----------------------------------------------------------------------------
module smpq_ctrl #(
    parameter int unsigned PRIORITY_LEVELS = smpq_pkg::DEF_PRIORITY_LEVELS,
    parameter int unsigned FIFO_DEPTH      = smpq_pkg::DEF_FIFO_DEPTH,
    localparam int unsigned LW = $clog2(PRIORITY_LEVELS),
    localparam int unsigned IW = $clog2(FIFO_DEPTH),
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1),
    localparam int unsigned AW = LW + IW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [smpq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [smpq_pkg::HANDLE_W-1:0] i_msg_handle,
    input  logic [smpq_pkg::SIZE_W-1:0]   i_msg_size,
    // downstream stage can take the held item
    input  logic                          i_advance,
    // slot store
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output logic [smpq_pkg::SLOT_W-1:0]   o_ram_wdata,
    output logic                          o_ram_re,
    output logic [AW-1:0]                 o_ram_raddr,
    // held item
    output smpq_pkg::t_s1_ctl             o_s1,
    output logic [LW-1:0]                 o_s1_lvl,
    output logic [smpq_pkg::SIZE_W-1:0]   o_s1_size,
    output logic [CW-1:0]                 o_s1_count
);

    logic [IW-1:0] r_head  [PRIORITY_LEVELS];
    logic [IW-1:0] r_tail  [PRIORITY_LEVELS];
    logic [CW-1:0] r_count [PRIORITY_LEVELS];

    smpq_pkg::t_s1_ctl              r_s1;
    logic [LW-1:0]                  r_s1_lvl;
    logic [smpq_pkg::SIZE_W-1:0]    r_s1_size;
    logic [CW-1:0]                  r_s1_count;

    logic                           accept;
    logic                           prio_ok;
    logic [LW-1:0]                  req_lvl;
    logic                           full;
    logic                           any_busy;
    logic [LW-1:0]                  sel_lvl;
    logic [LW-1:0]                  op_lvl;
    smpq_pkg::t_kind                kind;
    logic [CW-1:0]                  count_after;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        return (idx == IW'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign o_in_stall = r_s1.valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    assign prio_ok = (32'(i_priority_req) < PRIORITY_LEVELS);
    assign req_lvl = LW'(i_priority_req);
    assign full    = (r_count[req_lvl] == CW'(FIFO_DEPTH));

    // lowest-numbered non-empty FIFO wins
    always_comb begin
        any_busy = 1'b0;
        sel_lvl  = '0;
        for (int p = PRIORITY_LEVELS - 1; p >= 0; p--) begin
            if (r_count[p] != '0) begin
                any_busy = 1'b1;
                sel_lvl  = LW'(p);
            end
        end
    end

    always_comb begin
        if (i_command == smpq_pkg::CMD_DEQUEUE) begin
            kind   = any_busy ? smpq_pkg::KIND_DEQ : smpq_pkg::KIND_EMPTY;
            op_lvl = sel_lvl;
        end else begin
            op_lvl = req_lvl;
            if (!prio_ok) begin
                kind = smpq_pkg::KIND_IGNORE;
            end else if (full) begin
                kind = smpq_pkg::KIND_OVERFLOW;
            end else begin
                kind = smpq_pkg::KIND_ENQ;
            end
        end
    end

    always_comb begin
        unique case (kind)
            smpq_pkg::KIND_ENQ:      count_after = r_count[op_lvl] + 1'b1;
            smpq_pkg::KIND_DEQ:      count_after = r_count[op_lvl] - 1'b1;
            smpq_pkg::KIND_OVERFLOW: count_after = r_count[op_lvl];
            default:                 count_after = '0;
        endcase
    end

    assign o_ram_we    = accept && (kind == smpq_pkg::KIND_ENQ);
    assign o_ram_waddr = {req_lvl, r_tail[req_lvl]};
    assign o_ram_wdata = {i_msg_handle, i_msg_size};
    assign o_ram_re    = accept && (kind == smpq_pkg::KIND_DEQ);
    assign o_ram_raddr = {sel_lvl, r_head[sel_lvl]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PRIORITY_LEVELS; p++) begin
                r_head[p]  <= '0;
                r_tail[p]  <= '0;
                r_count[p] <= '0;
            end
        end else if (accept) begin
            if (kind == smpq_pkg::KIND_ENQ) begin
                r_tail[op_lvl]  <= next_idx(r_tail[op_lvl]);
                r_count[op_lvl] <= count_after;
            end else if (kind == smpq_pkg::KIND_DEQ) begin
                r_head[op_lvl]  <= next_idx(r_head[op_lvl]);
                r_count[op_lvl] <= count_after;
            end
        end
    end

    // valid is reset, the payload fields only load on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1.valid <= accept;
        end
        if (accept) begin
            r_s1.kind  <= kind;
            r_s1.prio  <= (i_command == smpq_pkg::CMD_DEQUEUE)
                          ? smpq_pkg::PRIO_W'(sel_lvl) : i_priority_req;
            r_s1_lvl   <= op_lvl;
            r_s1_size  <= i_msg_size;
            r_s1_count <= count_after;
        end
    end

    assign o_s1       = r_s1;
    assign o_s1_lvl   = r_s1_lvl;
    assign o_s1_size  = r_s1_size;
    assign o_s1_count = r_s1_count;

endmodule

// ===== rtl/core/smpq_acct.sv =====
// ----------------------------------------------------------------------------
// smpq_acct
// Result stage: capacity registers, used-bytes accounting, output register.
// ----------------------------------------------------------------------------
module smpq_acct #(
    parameter int unsigned PRIORITY_LEVELS = smpq_pkg::DEF_PRIORITY_LEVELS,
    parameter int unsigned FIFO_DEPTH      = smpq_pkg::DEF_FIFO_DEPTH,
    localparam int unsigned LW = $clog2(PRIORITY_LEVELS),
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [smpq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smpq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // held item from the input stage
    input  smpq_pkg::t_s1_ctl                  i_s1,
    input  logic [LW-1:0]                      i_s1_lvl,
    input  logic [smpq_pkg::SIZE_W-1:0]        i_s1_size,
    input  logic [CW-1:0]                      i_s1_count,
    input  logic [smpq_pkg::SLOT_W-1:0]        i_ram_rdata,
    output logic                               o_advance,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic [smpq_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic [smpq_pkg::PRIO_W-1:0]        o_out_priority,
    output logic [smpq_pkg::SIZE_W-1:0]        o_out_size,
    output logic                               o_overflow,
    output logic [smpq_pkg::BYTES_W-1:0]       o_level_bytes,
    output logic [smpq_pkg::LEVEL_COUNT_W-1:0] o_level_count
);

    localparam int unsigned BW = smpq_pkg::BYTES_W;

    logic [BW-1:0] r_capacity [smpq_pkg::NUM_CAP_REGS];
    logic [BW-1:0] r_bytes    [PRIORITY_LEVELS];

    logic                               r_out_valid;
    logic                               r_found;
    logic [smpq_pkg::HANDLE_W-1:0]      r_handle;
    logic [smpq_pkg::PRIO_W-1:0]        r_prio;
    logic [smpq_pkg::SIZE_W-1:0]        r_size;
    logic                               r_overflow;
    logic [BW-1:0]                      r_level_bytes;
    logic [smpq_pkg::LEVEL_COUNT_W-1:0] r_level_count;

    logic                               load;
    logic [BW-1:0]                      cap;
    logic [BW-1:0]                      cur;
    logic [smpq_pkg::HANDLE_W-1:0]      rd_handle;
    logic [smpq_pkg::SIZE_W-1:0]        rd_size;
    logic [BW:0]                        sum;
    logic [BW-1:0]                      diff;
    logic [BW-1:0]                      n_bytes;
    logic                               n_found;
    logic [smpq_pkg::HANDLE_W-1:0]      n_handle;
    logic [smpq_pkg::SIZE_W-1:0]        n_size;
    logic                               n_overflow;
    logic [BW-1:0]                      n_level_bytes;
    logic [smpq_pkg::LEVEL_COUNT_W-1:0] n_level_count;

    assign o_advance = !r_out_valid || !i_out_stall;
    assign load      = o_advance && i_s1.valid;

    assign rd_handle = i_ram_rdata[smpq_pkg::SLOT_W-1:smpq_pkg::SIZE_W];
    assign rd_size   = i_ram_rdata[smpq_pkg::SIZE_W-1:0];

    // priorities without a capacity register keep the reset limit
    assign cap = (32'(i_s1_lvl) < smpq_pkg::NUM_CAP_REGS)
                 ? r_capacity[smpq_pkg::CFG_IDX_W'(i_s1_lvl)] : smpq_pkg::CAP_RESET;
    assign cur = r_bytes[i_s1_lvl];

    assign sum  = {1'b0, cur} + {1'b0, i_s1_size};
    assign diff = (cur > rd_size) ? cur - rd_size : '0;

    always_comb begin
        n_found       = 1'b0;
        n_handle      = '0;
        n_size        = '0;
        n_overflow    = 1'b0;
        n_bytes       = cur;
        n_level_bytes = '0;
        n_level_count = '0;
        unique case (i_s1.kind)
            smpq_pkg::KIND_ENQ: begin
                n_bytes       = (sum > {1'b0, cap}) ? cap : BW'(sum);
                n_level_bytes = n_bytes;
                n_level_count = smpq_pkg::LEVEL_COUNT_W'(i_s1_count);
            end
            smpq_pkg::KIND_DEQ: begin
                n_bytes       = (diff > cap) ? cap : diff;
                n_found       = 1'b1;
                n_handle      = rd_handle;
                n_size        = rd_size;
                n_level_bytes = n_bytes;
                n_level_count = smpq_pkg::LEVEL_COUNT_W'(i_s1_count);
            end
            smpq_pkg::KIND_OVERFLOW: begin
                n_overflow    = 1'b1;
                n_level_bytes = cur;
                n_level_count = smpq_pkg::LEVEL_COUNT_W'(i_s1_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < smpq_pkg::NUM_CAP_REGS; i++) begin
                r_capacity[i] <= smpq_pkg::CAP_RESET;
            end
        end else if (i_cfg_we && (32'(i_cfg_index) < PRIORITY_LEVELS)) begin
            r_capacity[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PRIORITY_LEVELS; p++) begin
                r_bytes[p] <= '0;
            end
        end else if (load && (i_s1.kind == smpq_pkg::KIND_ENQ
                           || i_s1.kind == smpq_pkg::KIND_DEQ)) begin
            r_bytes[i_s1_lvl] <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_found       <= n_found;
            r_handle      <= n_handle;
            r_prio        <= (i_s1.kind == smpq_pkg::KIND_EMPTY) ? '0 : i_s1.prio;
            r_size        <= n_size;
            r_overflow    <= n_overflow;
            r_level_bytes <= n_level_bytes;
            r_level_count <= n_level_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_out_handle   = r_handle;
    assign o_out_priority = r_prio;
    assign o_out_size     = r_size;
    assign o_overflow     = r_overflow;
    assign o_level_bytes  = r_level_bytes;
    assign o_level_count  = r_level_count;

endmodule

// ===== rtl/core/strict_priority_message_queue.sv =====
// ----------------------------------------------------------------------------
// strict_priority_message_queue
// Per-priority FIFOs with strict-priority dequeue and used-bytes accounting.
// Pipeline: stage 1 loads its item at accept, the result register then loads
// it from stage 1 whenever the output is not stalled.
// Throughput: one item per cycle; a stalled result holds stage 1, which then
// stalls the input. Pointers and counts update at accept, the read slot and
// the used-bytes update are handled in the second stage.
// Reset (synchronous, active low): every FIFO empty, counters zero,
// capacities 65536; the slot store is not cleared.
// ----------------------------------------------------------------------------
module strict_priority_message_queue #(
    parameter int unsigned PRIORITY_LEVELS = smpq_pkg::DEF_PRIORITY_LEVELS,
    parameter int unsigned FIFO_DEPTH      = smpq_pkg::DEF_FIFO_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic [smpq_pkg::PRIO_W-1:0]        i_priority_req,
    input  logic [smpq_pkg::HANDLE_W-1:0]      i_msg_handle,
    input  logic [smpq_pkg::SIZE_W-1:0]        i_msg_size,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic [smpq_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic [smpq_pkg::PRIO_W-1:0]        o_out_priority,
    output logic [smpq_pkg::SIZE_W-1:0]        o_out_size,
    output logic                               o_overflow,
    output logic [smpq_pkg::BYTES_W-1:0]       o_level_bytes,
    output logic [smpq_pkg::LEVEL_COUNT_W-1:0] o_level_count,
    // configuration write port (capacity of priority = index)
    input  logic                               i_cfg_we,
    input  logic [smpq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smpq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned LW = $clog2(PRIORITY_LEVELS);
    localparam int unsigned IW = $clog2(FIFO_DEPTH);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned AW = LW + IW;
    // slot address is {priority, index}; unused rows simply stay idle
    localparam int unsigned RAM_DEPTH = 2 ** AW;

    logic                          advance;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [smpq_pkg::SLOT_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [smpq_pkg::SLOT_W-1:0]   ram_rdata;
    smpq_pkg::t_s1_ctl             s1;
    logic [LW-1:0]                 s1_lvl;
    logic [smpq_pkg::SIZE_W-1:0]   s1_size;
    logic [CW-1:0]                 s1_count;

    // Stage 1: picks the FIFO, moves head/tail/count, writes or reads the slot.
    // It holds its item while the output register is full and stalled.
    smpq_ctrl #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .FIFO_DEPTH      (FIFO_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_priority_req (i_priority_req),
        .i_msg_handle   (i_msg_handle),
        .i_msg_size     (i_msg_size),
        .i_advance      (advance),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .o_s1           (s1),
        .o_s1_lvl       (s1_lvl),
        .o_s1_size      (s1_size),
        .o_s1_count     (s1_count)
    );

    // Slot store: handle in the upper half, size in the lower half.
    // Read data holds while stage 1 is stalled since no new read is issued.
    smpq_ram #(
        .WIDTH (smpq_pkg::SLOT_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Stage 2: saturating used-bytes update and the output register.
    // Only this stage touches the byte counters, so updates stay in order.
    smpq_acct #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .FIFO_DEPTH      (FIFO_DEPTH)
    ) u_acct (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s1           (s1),
        .i_s1_lvl       (s1_lvl),
        .i_s1_size      (s1_size),
        .i_s1_count     (s1_count),
        .i_ram_rdata    (ram_rdata),
        .o_advance      (advance),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_out_handle   (o_out_handle),
        .o_out_priority (o_out_priority),
        .o_out_size     (o_out_size),
        .o_overflow     (o_overflow),
        .o_level_bytes  (o_level_bytes),
        .o_level_count  (o_level_count)
    );

endmodule

// ===== rtl/core/smpq_checker.sv =====
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks for the strict-priority message queue, bound to the top.
// ----------------------------------------------------------------------------
module smpq_checker #(
    parameter int unsigned FIFO_DEPTH = smpq_pkg::DEF_FIFO_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic                               o_found,
    input  logic [smpq_pkg::HANDLE_W-1:0]      o_out_handle,
    input  logic [smpq_pkg::SIZE_W-1:0]        o_out_size,
    input  logic                               o_overflow,
    input  logic [smpq_pkg::LEVEL_COUNT_W-1:0] o_level_count
);

    // no message means no handle and no size
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_out_handle == '0 && o_out_size == '0))
        else $error("result without message carries handle or size");

    // a rejected enqueue reports a full FIFO and never a message
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |->
        (!o_found && o_level_count == smpq_pkg::LEVEL_COUNT_W'(FIFO_DEPTH)))
        else $error("overflow result inconsistent");

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_handle)))
        else $error("stalled result dropped or changed");

endmodule

bind strict_priority_message_queue smpq_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_smpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_found       (o_found),
    .o_out_handle  (o_out_handle),
    .o_out_size    (o_out_size),
    .o_overflow    (o_overflow),
    .o_level_count (o_level_count)
);

// ===== tb/sv/strict_priority_message_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_priority_message_queue_tb
// Self-checking bench for the strict-priority message queue. A scoreboard
// class keeps its own copy of the FIFOs, counters and capacities, predicts one
// response per accepted command and checks each accepted response in order.
// Directed commands cover the corner cases. Random bursts then run through
// several capacity settings, with sender gaps, receiver stalls and a long
// output hold-off.
// ----------------------------------------------------------------------------
module strict_priority_message_queue_tb;

    import smpq_pkg::*;

    localparam int LEVELS          = DEF_PRIORITY_LEVELS;
    localparam int DEPTH           = DEF_FIFO_DEPTH;
    localparam int RESET_CYCLES    = 9;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 234;
    localparam int PRESSURE_PHASE  = 4;     // long receiver hold-off mid-phase
    localparam int PAUSE_PHASE     = 6;     // sender drains the block mid-phase
    localparam int LONG_HOLD       = 80;
    localparam int SETTLE_CYCLES   = 4;     // quiet cycles before a config write
    localparam int TAIL_CYCLES     = 8;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct {
        logic                     found;
        logic [HANDLE_W-1:0]      handle;
        logic [PRIO_W-1:0]        prio;
        logic [SIZE_W-1:0]        size;
        logic                     overflow;
        logic [BYTES_W-1:0]       bytes;
        logic [LEVEL_COUNT_W-1:0] count;
    } queue_response_t;

    typedef logic [NUM_CAP_REGS-1:0][CFG_DATA_W-1:0] cap_set_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow queue state plus the responses still awaited
    // ------------------------------------------------------------------------
    class queue_scoreboard;
        logic [BYTES_W-1:0]  capacity    [LEVELS];
        logic [HANDLE_W-1:0] slot_handle [LEVELS][DEPTH];
        logic [SIZE_W-1:0]   slot_size   [LEVELS][DEPTH];
        int                  head        [LEVELS];
        int                  tail        [LEVELS];
        int                  count       [LEVELS];
        logic [BYTES_W-1:0]  used        [LEVELS];
        queue_response_t     awaited_responses [$];
        int                  mismatches;

        function new();
            for (int p = 0; p < LEVELS; p++) begin
                capacity[p] = CAP_RESET;
                head[p]     = 0;
                tail[p]     = 0;
                count[p]    = 0;
                used[p]     = '0;
            end
            mismatches = 0;
        endfunction

        function void set_capacity(int idx, logic [CFG_DATA_W-1:0] value);
            if (idx < LEVELS) capacity[idx] = value;
        endfunction

        function int wrap_next(int i);
            return (i + 1 >= DEPTH) ? 0 : i + 1;
        endfunction

        // Advance the shadow state for one accepted command and queue the
        // response it must produce.
        function void record_command(logic cmd, logic [PRIO_W-1:0] prio,
                                     logic [HANDLE_W-1:0] handle, logic [SIZE_W-1:0] size);
            queue_response_t rsp;
            logic [BYTES_W:0] total;
            int p;
            rsp = '{default: '0};
            if (cmd == CMD_ENQUEUE) begin
                p = prio;
                rsp.prio = prio;
                if (count[p] >= DEPTH) begin
                    // full FIFO: counters untouched, no clamp either
                    rsp.overflow = 1'b1;
                end else begin
                    slot_handle[p][tail[p]] = handle;
                    slot_size[p][tail[p]]   = size;
                    tail[p]  = wrap_next(tail[p]);
                    count[p] = count[p] + 1;
                    total = {1'b0, used[p]} + {1'b0, size};
                    if (total > {1'b0, capacity[p]}) total = {1'b0, capacity[p]};
                    used[p] = total[BYTES_W-1:0];
                end
                rsp.bytes = used[p];
                rsp.count = LEVEL_COUNT_W'(count[p]);
            end else begin
                // strict priority: lowest-numbered non-empty FIFO wins
                for (p = 0; p < LEVELS; p++) begin
                    if (count[p] != 0) begin
                        rsp.found  = 1'b1;
                        rsp.handle = slot_handle[p][head[p]];
                        rsp.size   = slot_size[p][head[p]];
                        rsp.prio   = PRIO_W'(p);
                        head[p]  = wrap_next(head[p]);
                        count[p] = count[p] - 1;
                        used[p]  = (used[p] > rsp.size) ? used[p] - rsp.size : '0;
                        if (used[p] > capacity[p]) used[p] = capacity[p];
                        rsp.bytes = used[p];
                        rsp.count = LEVEL_COUNT_W'(count[p]);
                        break;
                    end
                end
            end
            awaited_responses.push_back(rsp);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(queue_response_t got);
            queue_response_t want;
            if (awaited_responses.size() == 0) begin
                $error("response with none awaited: handle 0x%08h prio %0d",
                       got.handle, got.prio);
                mismatches++;
                return;
            end
            want = awaited_responses.pop_front();
            compare_field("found",       32'(want.found),    32'(got.found));
            compare_field("out_handle",  32'(want.handle),   32'(got.handle));
            compare_field("out_priority", 32'(want.prio),    32'(got.prio));
            compare_field("out_size",    32'(want.size),     32'(got.size));
            compare_field("overflow",    32'(want.overflow), 32'(got.overflow));
            compare_field("level_bytes", 32'(want.bytes),    32'(got.bytes));
            compare_field("level_count", 32'(want.count),    32'(got.count));
        endfunction

        function int pending();
            return awaited_responses.size();
        endfunction

        function void flag_leftovers();
            if (awaited_responses.size() != 0) begin
                $error("%0d responses never arrived", awaited_responses.size());
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, the inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic                     i_command      = CMD_ENQUEUE;
    logic [PRIO_W-1:0]        i_priority_req = '0;
    logic [HANDLE_W-1:0]      i_msg_handle   = '0;
    logic [SIZE_W-1:0]        i_msg_size     = '0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic                     o_found;
    logic [HANDLE_W-1:0]      o_out_handle;
    logic [PRIO_W-1:0]        o_out_priority;
    logic [SIZE_W-1:0]        o_out_size;
    logic                     o_overflow;
    logic [BYTES_W-1:0]       o_level_bytes;
    logic [LEVEL_COUNT_W-1:0] o_level_count;
    logic                     i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data     = '0;

    // traffic shaping, percent per cycle
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic long_hold_req      = 1'b0;
    int   hold_left          = 0;
    int   cycle_count        = 0;

    queue_scoreboard board = new();

    strict_priority_message_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_priority_req (i_priority_req),
        .i_msg_handle   (i_msg_handle),
        .i_msg_size     (i_msg_size),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_out_handle   (o_out_handle),
        .o_out_priority (o_out_priority),
        .o_out_size     (o_out_size),
        .o_overflow     (o_overflow),
        .o_level_bytes  (o_level_bytes),
        .o_level_count  (o_level_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: only reached when the run hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("strict_priority_message_queue_tb: done, errors");
        $finish;
    end

    // Receiver: checks what was accepted at this edge, then picks the stall
    // for the next cycle. A long hold-off request is counted down here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                board.check_response('{found: o_found, handle: o_out_handle,
                                       prio: o_out_priority, size: o_out_size,
                                       overflow: o_overflow, bytes: o_level_bytes,
                                       count: o_level_count});
            end
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Offer one command, with random idle cycles ahead of it; returns at the
    // edge where it was accepted. Valid gets one assignment per time step.
    task automatic send_item(input logic cmd, input logic [PRIO_W-1:0] prio,
                             input logic [HANDLE_W-1:0] handle,
                             input logic [SIZE_W-1:0] size);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_priority_req <= prio;
        i_msg_handle   <= handle;
        i_msg_size     <= size;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.record_command(cmd, prio, handle, size);
    endtask

    // Dequeue fields are don't-care, so keep them moving.
    task automatic send_dequeue();
        send_item(CMD_DEQUEUE, PRIO_W'($urandom_range(3)), $urandom(), $urandom());
    endtask

    task automatic pause_sender_until_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Block is idle when this runs; one register per cycle.
    task automatic load_capacities(input cap_set_t caps);
        for (int i = 0; i < NUM_CAP_REGS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= caps[i];
            @(posedge i_clk);
            board.set_capacity(i, caps[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic cap_set_t phase_capacities(int ph);
        cap_set_t caps;
        case (ph)
            0: caps = {4{CAP_RESET}};
            1: caps = {32'd255, 32'd1000, 32'hFFFF_FFFF, 32'd0};
            2: caps = {4{32'hFFFF_FFFF}};
            3: caps = {32'd50000, 32'hFFFF_FFFF, 32'd0, 32'd100};
            7: caps = {32'd0, CAP_RESET, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
            default: begin
                for (int i = 0; i < NUM_CAP_REGS; i++)
                    caps[i] = ($urandom_range(1) == 0) ? $urandom_range(200000) : $urandom();
            end
        endcase
        return caps;
    endfunction

    // Sizes lean toward the interesting ends: zero, all ones, small values.
    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        if (roll < 60) return SIZE_W'($urandom_range(255));
        return $urandom();
    endfunction

    // Random traffic in bursts: each burst leans toward enqueue, dequeue or
    // a mix, and often sticks to one priority so FIFOs fill and overflow.
    task automatic send_random_items(input int total);
        int         sent;
        int         burst_left;
        int         enq_pct;
        int         focus_prio;
        logic [PRIO_W-1:0] prio;
        sent       = 0;
        burst_left = 0;
        enq_pct    = 50;
        focus_prio = -1;
        while (sent < total) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 15;
                endcase
                focus_prio = ($urandom_range(1) == 0) ? -1 : int'($urandom_range(3));
            end
            prio = (focus_prio < 0) ? PRIO_W'($urandom_range(3)) : PRIO_W'(focus_prio);
            if ($urandom_range(99) < enq_pct)
                send_item(CMD_ENQUEUE, prio, $urandom(), pick_size());
            else
                send_dequeue();
            burst_left--;
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset capacities of 65536 in force.
        send_dequeue();                                          // all FIFOs empty
        send_item(CMD_ENQUEUE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // saturates
        send_item(CMD_ENQUEUE, 2'd3, 32'h0000_0000, 32'd0);      // zero size
        send_item(CMD_ENQUEUE, 2'd1, 32'h1234_5678, 32'd100);
        send_dequeue();                                          // priority 1 first
        send_dequeue();                                          // size above usage: floor
        send_dequeue();                                          // zero size still counts
        // fill priority 2, then one more to overflow
        for (int i = 0; i <= DEPTH; i++)
            send_item(CMD_ENQUEUE, 2'd2, 32'hA5A5_0000 | i, 32'd5000);
        send_item(CMD_ENQUEUE, 2'd0, 32'h5A5A_5A5A, 32'd7);
        send_dequeue();                                          // priority 0 beats 2

        // Random phases; priority 2 carries its backlog into the first phase, at reset capacities.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pause_sender_until_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            load_capacities(phase_capacities(ph));
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
                default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
            endcase
            if (ph == PRESSURE_PHASE) begin
                send_random_items(ITEMS_PER_PHASE / 2);
                long_hold_req <= 1'b1;    // output frozen while input keeps coming
                send_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end else if (ph == PAUSE_PHASE) begin
                send_random_items(ITEMS_PER_PHASE / 2);
                pause_sender_until_drained();
                send_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end else begin
                send_random_items(ITEMS_PER_PHASE);
            end
        end

        pause_sender_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        board.flag_leftovers();
        if (board.mismatches == 0) begin
            $display("strict_priority_message_queue_tb: done, clean");
        end else begin
            $display("strict_priority_message_queue_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/smpq_pkg.sv
rtl/core/smpq_ram.sv
rtl/core/smpq_ctrl.sv
rtl/core/smpq_acct.sv
rtl/core/strict_priority_message_queue.sv
rtl/core/smpq_checker.sv
tb/sv/strict_priority_message_queue_tb.sv
